// ----- src/bpfm_pkg.sv -----
//------------------------------------------------------------------------------
// bpfm_pkg
// Shared types, constants and command/status structs of the frame manager.
//------------------------------------------------------------------------------
package bpfm_pkg;

    localparam int FRAMES_DEF    = 16;
    localparam int FILES_DEF     = 16;
    localparam int PAGE_BITS_DEF = 20;

    localparam int OP_W     = 3;
    localparam int FILE_W   = 4;
    localparam int PAGE_W   = 20;
    localparam int FIDX_W   = 4;
    localparam int STATUS_W = 2;
    localparam int PIN_W    = 8;
    localparam int STAMP_W  = 32;

    localparam logic [OP_W-1:0] OP_FETCH   = 3'd0;
    localparam logic [OP_W-1:0] OP_UNPIN   = 3'd1;
    localparam logic [OP_W-1:0] OP_DIRTY   = 3'd2;
    localparam logic [OP_W-1:0] OP_DISPOSE = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BUFFER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PINNED    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, reset scan
        logic scan;       // examine entry at scan pointer, advance
        logic fetch_hit;  // commit hit on found frame
        logic fetch_miss; // install page into victim
        logic dispose;    // free found frame
        logic flush_step; // free frame at scan pointer (flush)
        logic direct;     // unpin / mark dirty
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic found_pinned;
        logic have_victim;
        logic cur_flush_dirty; // entry at pointer is dirty & belongs to file
        logic cur_flush_match;
        logic more_dirty;      // a later dirty frame of the file exists
    } t_sts;

endpackage

// ----- src/bpfm_ctrl.sv -----
//------------------------------------------------------------------------------
// bpfm_ctrl
// Request sequencer: drives the frame scan and emits result transactions.
//------------------------------------------------------------------------------
module bpfm_ctrl #(
    parameter int FILES = bpfm_pkg::FILES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bpfm_pkg::OP_W-1:0]    i_op,
    input  logic [bpfm_pkg::FILE_W-1:0]  i_file_id,
    output bpfm_pkg::t_cmd               o_cmd,
    input  bpfm_pkg::t_sts               i_sts,
    output logic                         o_valid,
    input  logic                         i_out_ready,
    output logic [bpfm_pkg::STATUS_W-1:0] o_status,
    output logic                         o_hit,
    output logic                         o_wb,
    output logic                         o_last,
    output logic                         o_frame_sel, // take frame from datapath
    output logic                         o_wb_sel     // take wb fields from datapath
);
    import bpfm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_FLUSH, S_OUT} t_state;

    t_state                r_state;
    logic [OP_W-1:0]       r_op;
    logic                  r_file_ok;
    logic                  r_flush_any;

    logic                  out_free;
    logic                  in_file_ok;
    logic                  emit;        // output register takes a transaction
    logic [STATUS_W-1:0]   n_status;
    logic                  n_hit;
    logic                  n_wb;
    logic                  n_last;

    assign out_free   = !o_valid || i_out_ready;
    assign o_ready    = (r_state == S_IDLE) && out_free;
    assign in_file_ok = (32'(i_file_id) < FILES);

    always_comb begin
        o_cmd       = '0;
        emit        = 1'b0;
        n_status    = ST_OK;
        n_hit       = 1'b0;
        n_wb        = 1'b0;
        n_last      = 1'b1;
        o_frame_sel = 1'b0;
        o_wb_sel    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.direct = (i_op == OP_UNPIN) || (i_op == OP_DIRTY);
                    // everything but a table walk answers at once
                    emit = !((i_op == OP_FETCH) || (i_op == OP_DISPOSE)
                             || (i_op == OP_FLUSH && in_file_ok));
                end
            end
            S_SCAN:   o_cmd.scan = !i_sts.scan_done;
            S_DECIDE: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_file_ok && r_op == OP_FETCH) begin
                        if (i_sts.found) begin
                            o_cmd.fetch_hit = 1'b1;
                            n_hit           = 1'b1;
                            o_frame_sel     = 1'b1;
                        end else if (i_sts.have_victim) begin
                            o_cmd.fetch_miss = 1'b1;
                            o_frame_sel      = 1'b1;
                            o_wb_sel         = i_sts.cur_flush_dirty;
                            n_wb             = i_sts.cur_flush_dirty;
                        end else begin
                            n_status = ST_NO_BUFFER;
                        end
                    end else if (r_file_ok && r_op == OP_DISPOSE && i_sts.found) begin
                        if (i_sts.found_pinned)
                            n_status = ST_PINNED;
                        else
                            o_cmd.dispose = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                o_cmd.flush_step = !i_sts.cur_flush_dirty || out_free;
                if (i_sts.cur_flush_dirty && out_free) begin
                    // transaction for this dirty frame
                    emit     = 1'b1;
                    n_wb     = 1'b1;
                    n_last   = !i_sts.more_dirty;
                    o_wb_sel = 1'b1;
                end
            end
            S_OUT:    emit = out_free;
            default:  emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_valid     <= 1'b0;
            r_op        <= '0;
            r_file_ok   <= 1'b0;
            r_flush_any <= 1'b0;
            o_status    <= ST_OK;
            o_hit       <= 1'b0;
            o_wb        <= 1'b0;
            o_last      <= 1'b0;
        end else begin
            o_valid <= emit || (o_valid && !i_out_ready);
            if (emit) begin
                o_status <= n_status;
                o_hit    <= n_hit;
                o_wb     <= n_wb;
                o_last   <= n_last;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op        <= i_op;
                        r_file_ok   <= in_file_ok;
                        r_flush_any <= 1'b0;
                        if (i_op == OP_FETCH || i_op == OP_DISPOSE)
                            r_state <= S_SCAN;
                        else if (i_op == OP_FLUSH && in_file_ok)
                            r_state <= S_FLUSH;
                    end
                end
                S_SCAN: begin
                    if (i_sts.scan_done)
                        r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (out_free)
                        r_state <= S_IDLE;
                end
                S_FLUSH: begin
                    if (i_sts.cur_flush_dirty) begin
                        if (out_free) begin
                            r_flush_any <= 1'b1;
                            if (i_sts.scan_done)
                                r_state <= S_IDLE;
                        end
                    end else if (i_sts.scan_done) begin
                        if (r_flush_any)
                            r_state <= S_IDLE;
                        else
                            r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // flush found nothing dirty: single closing transaction
                    if (out_free)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- src/bpfm_dp.sv -----
//------------------------------------------------------------------------------
// bpfm_dp
// Frame table and scan datapath: one entry examined per cycle unless flush stalls.
//------------------------------------------------------------------------------
module bpfm_dp #(
    parameter int FRAMES    = bpfm_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = bpfm_pkg::PAGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpfm_pkg::t_cmd                i_cmd,
    output bpfm_pkg::t_sts                o_sts,
    input  logic [bpfm_pkg::OP_W-1:0]     i_op,
    input  logic [bpfm_pkg::FILE_W-1:0]   i_file_id,
    input  logic [bpfm_pkg::PAGE_W-1:0]   i_page_num,
    input  logic [bpfm_pkg::FIDX_W-1:0]   i_frame_index,
    input  logic                          i_frame_sel,
    input  logic                          i_wb_sel,
    input  logic                          i_wb_load,   // output register is free to take a new item
    output logic [bpfm_pkg::FIDX_W-1:0]   o_frame_out,
    output logic [bpfm_pkg::FILE_W-1:0]   o_wb_file_id,
    output logic [bpfm_pkg::PAGE_W-1:0]   o_wb_page_num
);
    import bpfm_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam logic [PIN_W-1:0]   PIN_MAX   = '1;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    logic [FRAMES-1:0]    r_valid;
    logic [FRAMES-1:0]    r_dirty;
    logic [FILE_W-1:0]    r_file  [FRAMES];
    logic [PAGE_BITS-1:0] r_page  [FRAMES];
    logic [PIN_W-1:0]     r_pins  [FRAMES];
    logic [STAMP_W-1:0]   r_stamp [FRAMES];
    logic [STAMP_W-1:0]   r_counter;

    logic [FILE_W-1:0]    r_qfile;
    logic [PAGE_BITS-1:0] r_qpage;
    logic [CW-1:0]        r_ptr;
    logic                 r_found;
    logic [IW-1:0]        r_fidx;
    logic                 r_free_any;
    logic [IW-1:0]        r_free_idx;
    logic                 r_lru_any;
    logic [IW-1:0]        r_lru_idx;
    logic [STAMP_W-1:0]   r_lru_stamp;
    logic [FRAMES-1:0]    r_pend;    // dirty frames of flushed file still to report

    logic [IW-1:0]        cur;
    logic [IW-1:0]        victim;
    logic [IW-1:0]        didx;
    logic [STAMP_W-1:0]   stamp_nxt;
    logic                 cur_match;
    logic [FRAMES-1:0]    later_mask;
    logic [FRAMES-1:0]    n_pend;

    assign cur       = r_ptr[IW-1:0];
    assign victim    = r_free_any ? r_free_idx : r_lru_idx;
    assign didx      = IW'(i_frame_index);
    assign stamp_nxt = (r_counter == STAMP_MAX) ? r_counter : r_counter + 1'b1;
    assign cur_match = r_valid[cur] && (r_file[cur] == r_qfile);

    always_comb begin
        for (int k = 0; k < FRAMES; k++)
            later_mask[k] = (k > 32'(cur));
    end

    always_comb begin
        o_sts = '0;
        // flush finishes as the last frame is stepped
        o_sts.scan_done    = (i_op == OP_FLUSH) ? (32'(r_ptr) >= FRAMES - 1)
                                                : (r_ptr == CW'(FRAMES));
        o_sts.found        = r_found;
        o_sts.found_pinned = r_pins[r_fidx] != '0;
        o_sts.have_victim  = r_free_any || r_lru_any;
        o_sts.cur_flush_match = 1'b0;
        o_sts.more_dirty   = 1'b0;
        if (r_ptr != CW'(FRAMES)) begin
            o_sts.cur_flush_match = cur_match;
            o_sts.more_dirty      = (r_pend & later_mask) != '0;
        end
        // in decide: victim dirty flag; in flush: current frame to report
        if (r_ptr == CW'(FRAMES) && i_op == OP_FETCH)
            o_sts.cur_flush_dirty = !r_free_any && r_valid[victim] && r_dirty[victim];
        else
            o_sts.cur_flush_dirty = (r_ptr != CW'(FRAMES)) && cur_match && r_dirty[cur];
    end

    always_comb begin
        n_pend = r_pend;
        if (r_ptr != CW'(FRAMES)) n_pend[cur] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_dirty   <= '0;
            r_counter <= '0;
            r_ptr     <= CW'(FRAMES);
            r_pend    <= '0;
            for (int k = 0; k < FRAMES; k++) begin
                r_pins[k]  <= '0;
                r_stamp[k] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_qfile    <= i_file_id;
                r_qpage    <= PAGE_BITS'(i_page_num);
                r_ptr      <= '0;
                r_found    <= 1'b0;
                r_fidx     <= '0;
                r_free_any <= 1'b0;
                r_free_idx <= '0;
                r_lru_any  <= 1'b0;
                r_lru_idx  <= '0;
                r_lru_stamp <= '0;
                for (int k = 0; k < FRAMES; k++)
                    r_pend[k] <= r_valid[k] && r_dirty[k] && (r_file[k] == i_file_id);
            end
            if (i_cmd.direct && 32'(i_frame_index) < FRAMES) begin
                if (i_op == OP_UNPIN) begin
                    if (r_pins[didx] != '0)
                        r_pins[didx] <= r_pins[didx] - 1'b1;
                end else begin
                    r_dirty[didx] <= 1'b1;
                end
            end
            if (i_cmd.scan) begin
                if (!r_found && r_valid[cur] && r_file[cur] == r_qfile
                    && r_page[cur] == r_qpage) begin
                    r_found <= 1'b1;
                    r_fidx  <= cur;
                end
                if (!r_free_any && !r_valid[cur]) begin
                    r_free_any <= 1'b1;
                    r_free_idx <= cur;
                end
                if (r_pins[cur] == '0 && (!r_lru_any || r_stamp[cur] < r_lru_stamp)) begin
                    r_lru_any   <= 1'b1;
                    r_lru_idx   <= cur;
                    r_lru_stamp <= r_stamp[cur];
                end
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.fetch_hit) begin
                if (r_pins[r_fidx] != PIN_MAX)
                    r_pins[r_fidx] <= r_pins[r_fidx] + 1'b1;
                r_stamp[r_fidx] <= stamp_nxt;
                r_counter       <= stamp_nxt;
            end
            if (i_cmd.fetch_miss) begin
                r_valid[victim] <= 1'b1;
                r_file[victim]  <= r_qfile;
                r_page[victim]  <= r_qpage;
                r_pins[victim]  <= PIN_W'(1);
                r_dirty[victim] <= 1'b0;
                r_stamp[victim] <= stamp_nxt;
                r_counter       <= stamp_nxt;
            end
            if (i_cmd.dispose) begin
                r_valid[r_fidx] <= 1'b0;
                r_pins[r_fidx]  <= '0;
                r_dirty[r_fidx] <= 1'b0;
            end
            if (i_cmd.flush_step && r_ptr != CW'(FRAMES)) begin
                if (cur_match) begin
                    r_valid[cur] <= 1'b0;
                    r_pins[cur]  <= '0;
                    r_dirty[cur] <= 1'b0;
                end
                r_pend <= n_pend;
                r_ptr  <= r_ptr + 1'b1;
            end
        end
    end

    // result payload registers, loaded whenever the controller's output register is free
    always_ff @(posedge i_clk) begin
        if (i_wb_load) begin
            o_frame_out <= i_frame_sel ? FIDX_W'(r_found ? r_fidx : victim) : '0;
            if (i_wb_sel) begin
                o_wb_file_id  <= (i_op == OP_FLUSH) ? r_file[cur] : r_file[victim];
                o_wb_page_num <= PAGE_W'((i_op == OP_FLUSH) ? r_page[cur] : r_page[victim]);
            end else begin
                o_wb_file_id  <= '0;
                o_wb_page_num <= '0;
            end
        end
    end
endmodule

// ----- src/buffer_pool_frame_manager.sv -----
//------------------------------------------------------------------------------
// buffer_pool_frame_manager
// LRU page buffer pool frame table with pin counts.
//------------------------------------------------------------------------------
// One request is taken at a time. Fetch and dispose walk the frame table one
// entry per cycle, then decide and emit their transaction once the output
// register is free; the next request can be taken after that. They walk the
// table for a file id out of range too. Unpin, mark dirty, an unknown op and
// a flush of a file out of range answer at once, and the next request can be
// taken as soon as the output register is free. Flush steps one frame per
// cycle, holding on a dirty frame while the output is stalled, and emits one
// transaction per dirty frame, or a single closing one when nothing was dirty.
// The datapath has a single frame scan pointer, used by both walks.
module buffer_pool_frame_manager #(
    parameter int FRAMES    = bpfm_pkg::FRAMES_DEF,
    parameter int FILES     = bpfm_pkg::FILES_DEF,
    parameter int PAGE_BITS = bpfm_pkg::PAGE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [bpfm_pkg::OP_W-1:0]      i_op,
    input  logic [bpfm_pkg::FILE_W-1:0]    i_file_id,
    input  logic [bpfm_pkg::PAGE_W-1:0]    i_page_num,
    input  logic [bpfm_pkg::FIDX_W-1:0]    i_frame_index,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bpfm_pkg::STATUS_W-1:0]  o_status,
    output logic [bpfm_pkg::FIDX_W-1:0]    o_frame_out,
    output logic                           o_hit,
    output logic                           o_writeback,
    output logic [bpfm_pkg::FILE_W-1:0]    o_wb_file_id,
    output logic [bpfm_pkg::PAGE_W-1:0]    o_wb_page_num,
    output logic                           o_last
);
    import bpfm_pkg::*;

    t_cmd            cmd;
    t_sts            sts;
    logic            frame_sel;
    logic            wb_sel;
    logic [OP_W-1:0] r_op;
    logic [OP_W-1:0] dp_op;
    logic            wb_load;
    logic            prev_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            if (cmd.load || (i_valid && o_ready)) r_op <= i_op;
        end
    end

    // unpin and mark dirty act in the accepting cycle, on the live op
    assign dp_op = (i_valid && o_ready) ? i_op : r_op;

    // payload registers load whenever the output register is free
    assign prev_valid = o_valid && !i_ready;
    assign wb_load    = !prev_valid;

    bpfm_ctrl #(.FILES(FILES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_file_id   (i_file_id),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_valid     (o_valid),
        .i_out_ready (i_ready),
        .o_status    (o_status),
        .o_hit       (o_hit),
        .o_wb        (o_writeback),
        .o_last      (o_last),
        .o_frame_sel (frame_sel),
        .o_wb_sel    (wb_sel)
    );

    bpfm_dp #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (dp_op),
        .i_file_id     (i_file_id),
        .i_page_num    (i_page_num),
        .i_frame_index (i_frame_index),
        .i_frame_sel   (frame_sel),
        .i_wb_sel      (wb_sel),
        .i_wb_load     (wb_load),
        .o_frame_out   (o_frame_out),
        .o_wb_file_id  (o_wb_file_id),
        .o_wb_page_num (o_wb_page_num)
    );
endmodule
